@@ rtl/core/mips_subset_instruction_executor_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the instruction executor
// Shared property shapes used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef MIPS_SUBSET_INSTRUCTION_EXECUTOR_DEFINES_SVH
`define MIPS_SUBSET_INSTRUCTION_EXECUTOR_DEFINES_SVH

// Same-cycle implication, sampled on clk and ignored while in reset.
`define MSE_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and ignored while in reset.
`define MSE_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/mse_pkg.sv @@
// ----------------------------------------------------------------------------
// mse_pkg
// Opcodes, function codes and shared types of the instruction executor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mse_pkg;

    // Primary opcodes (instruction bits 31:26).
    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_SW    = 6'h2b;
    localparam logic [5:0] OP_BEQ   = 6'h04;

    // R-type function codes (instruction bits 5:0).
    localparam logic [5:0] FN_ADD = 6'h20;
    localparam logic [5:0] FN_AND = 6'h24;
    localparam logic [5:0] FN_OR  = 6'h25;
    localparam logic [5:0] FN_NOR = 6'h27;
    localparam logic [5:0] FN_SLT = 6'h2a;

    // The halt word only raises a flag.
    localparam logic [31:0] HALT_WORD = 32'h0c00_0000;

    // Register file geometry.
    localparam int RF_DEPTH = 8;
    localparam int RF_AW    = 3;

    // Control and status of one executed word.
    typedef struct packed {
        logic             reg_wr;
        logic             is_load;
        logic             store;
        logic             addr_err;
        logic             halt;
        logic [RF_AW-1:0] dest;
        logic [4:0]       addr5;
    } exec_ctl_t;

endpackage

@@ rtl/core/mse_ram.sv @@
// ----------------------------------------------------------------------------
// mse_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port; returns the old contents on a same-address write.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/mse_exec.sv @@
// ----------------------------------------------------------------------------
// mse_exec
// Decode and execute of one word: ALU, load/store address and next PC.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mse_exec #(
    parameter int MEM_WORDS = 32,
    parameter int PC_WIDTH  = 16
) (
    input  logic [31:0]                       instruction,
    input  logic [31:0]                       op_a,
    input  logic [31:0]                       op_b,
    input  logic [PC_WIDTH-1:0]               pc,
    output mse_pkg::exec_ctl_t                ctl,
    output logic [31:0]                       wval,
    output logic [31:0]                       sval,
    output logic [PC_WIDTH-1:0]               npc,
    output logic [$clog2(MEM_WORDS)-1:0]      mem_index
);

    localparam int AW = $clog2(MEM_WORDS);

    logic [5:0]          opcode;
    logic [5:0]          funct;
    logic [31:0]         simm;
    logic [32:0]         addr_sum;
    logic                addr_ok;
    logic [PC_WIDTH-1:0] pc_inc;

    assign opcode = instruction[31:26];
    assign funct  = instruction[5:0];
    assign simm   = {{16{instruction[15]}}, instruction[15:0]};

    // Load/store address is computed without wrap, then range checked.
    assign addr_sum  = {op_a[31], op_a} + {simm[31], simm};
    assign addr_ok   = !addr_sum[32] && (addr_sum < 33'(MEM_WORDS));
    assign mem_index = addr_sum[AW-1:0];

    assign pc_inc = pc + PC_WIDTH'(1);

    // Operation select.
    always_comb
    begin
        ctl          = '0;
        ctl.halt     = (instruction == mse_pkg::HALT_WORD);
        wval         = '0;
        sval         = '0;
        npc          = pc_inc;
        unique case (opcode)
            mse_pkg::OP_RTYPE:
            begin
                ctl.reg_wr = 1'b1;
                ctl.dest   = instruction[13:11];
                unique case (funct)
                    mse_pkg::FN_ADD: wval = op_a + op_b;
                    mse_pkg::FN_AND: wval = op_a & op_b;
                    mse_pkg::FN_OR:  wval = op_a | op_b;
                    mse_pkg::FN_NOR: wval = ~(op_a | op_b);
                    mse_pkg::FN_SLT: wval = {31'b0, $signed(op_a) < $signed(op_b)};
                    default:
                    begin
                        ctl.reg_wr = 1'b0;
                        ctl.dest   = '0;
                    end
                endcase
            end
            mse_pkg::OP_LW:
            begin
                if (addr_ok)
                begin
                    ctl.reg_wr  = 1'b1;
                    ctl.is_load = 1'b1;
                    ctl.dest    = instruction[18:16];
                    ctl.addr5   = addr_sum[4:0];
                end
                else
                begin
                    ctl.addr_err = 1'b1;
                end
            end
            mse_pkg::OP_SW:
            begin
                if (addr_ok)
                begin
                    ctl.store = 1'b1;
                    ctl.addr5 = addr_sum[4:0];
                    sval      = op_b;
                end
                else
                begin
                    ctl.addr_err = 1'b1;
                end
            end
            mse_pkg::OP_BEQ:
            begin
                if (op_a == op_b)
                begin
                    npc = pc_inc + simm[PC_WIDTH-1:0];
                end
            end
            default:
            begin
                ctl.reg_wr = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/core/mips_subset_instruction_executor.sv @@
// ----------------------------------------------------------------------------
// mips_subset_instruction_executor
// An accepted word moves from the execute stage registers to the result stage
// registers. Throughput: one word per cycle while out_stall is low, register
// and load results forwarded. After reset a clearing pass zeroes the data
// memory and register file; in_stall stays high meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mips_subset_instruction_executor #(
    parameter int MEM_WORDS = 32,
    parameter int PC_WIDTH  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] instruction,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] next_pc,
    output logic        reg_written,
    output logic [2:0]  dest_index,
    output logic [31:0] dest_value,
    output logic        store_done,
    output logic [4:0]  store_address,
    output logic [31:0] store_value,
    output logic        address_error,
    output logic        halted
);

    localparam int AW        = $clog2(MEM_WORDS);
    localparam int CLR_COUNT = (MEM_WORDS > mse_pkg::RF_DEPTH) ? MEM_WORDS : mse_pkg::RF_DEPTH;
    localparam int CNT_W     = $clog2(CLR_COUNT);
    localparam logic [CNT_W:0] MEM_LIM = (CNT_W + 1)'(MEM_WORDS);
    localparam logic [CNT_W:0] RF_LIM  = (CNT_W + 1)'(mse_pkg::RF_DEPTH);

    // Control state.
    logic                clearing_reg, clearing_next;
    logic [CNT_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic                s1_valid_reg, s1_valid_next;
    logic                s2_valid_reg, s2_valid_next;
    logic                fwd_a_hit_reg, fwd_a_hit_next;
    logic                fwd_b_hit_reg, fwd_b_hit_next;
    logic [PC_WIDTH-1:0] pc_reg, pc_next;

    // Payload state.
    logic [31:0]         s1_ins_reg;
    logic [31:0]         fwd_a_val_reg;
    logic [31:0]         fwd_b_val_reg;
    mse_pkg::exec_ctl_t  s2_ctl_reg;
    logic [31:0]         s2_val_reg;
    logic [31:0]         s2_sval_reg;
    logic [PC_WIDTH-1:0] s2_npc_reg;

    // Datapath.
    logic                in_accept;
    logic                s1_adv;
    logic [31:0]         rf_a_rdata, rf_b_rdata;
    logic [31:0]         dm_rdata;
    logic                s2_wr;
    logic [31:0]         s2_wval;
    logic [31:0]         op_a, op_b;
    mse_pkg::exec_ctl_t  ex_ctl;
    logic [31:0]         ex_wval, ex_sval;
    logic [PC_WIDTH-1:0] ex_npc;
    logic [AW-1:0]       ex_mem_index;
    logic                rf_we;
    logic [mse_pkg::RF_AW-1:0] rf_waddr;
    logic [31:0]         rf_wdata;
    logic                dm_we;
    logic [AW-1:0]       dm_waddr;
    logic [31:0]         dm_wdata;
    logic [31:0]         npc_wide;

    // Handshake and stage movement.
    assign s1_adv    = s1_valid_reg && (!s2_valid_reg || !out_stall);
    assign in_stall  = clearing_reg || (s1_valid_reg && !s1_adv);
    assign in_accept = in_valid && !in_stall;

    // Writeback from the result stage; a load takes the memory read data.
    assign s2_wr   = s2_valid_reg && s2_ctl_reg.reg_wr;
    assign s2_wval = s2_ctl_reg.is_load ? dm_rdata : s2_val_reg;

    // Operand forwarding: the result stage first, then the word captured at accept.
    always_comb
    begin
        priority if (s2_wr && (s2_ctl_reg.dest == s1_ins_reg[23:21]))
            op_a = s2_wval;
        else if (fwd_a_hit_reg)
            op_a = fwd_a_val_reg;
        else
            op_a = rf_a_rdata;

        priority if (s2_wr && (s2_ctl_reg.dest == s1_ins_reg[18:16]))
            op_b = s2_wval;
        else if (fwd_b_hit_reg)
            op_b = fwd_b_val_reg;
        else
            op_b = rf_b_rdata;
    end

    mse_exec #(
        .MEM_WORDS (MEM_WORDS),
        .PC_WIDTH  (PC_WIDTH)
    ) u_exec (
        .instruction (s1_ins_reg),
        .op_a        (op_a),
        .op_b        (op_b),
        .pc          (pc_reg),
        .ctl         (ex_ctl),
        .wval        (ex_wval),
        .sval        (ex_sval),
        .npc         (ex_npc),
        .mem_index   (ex_mem_index)
    );

    // Write ports: the clearing pass owns them until it finishes.
    always_comb
    begin
        if (clearing_reg)
        begin
            rf_we    = ({1'b0, clr_cnt_reg} < RF_LIM);
            rf_waddr = clr_cnt_reg[mse_pkg::RF_AW-1:0];
            rf_wdata = '0;
            dm_we    = ({1'b0, clr_cnt_reg} < MEM_LIM);
            dm_waddr = clr_cnt_reg[AW-1:0];
            dm_wdata = '0;
        end
        else
        begin
            rf_we    = s2_wr;
            rf_waddr = s2_ctl_reg.dest;
            rf_wdata = s2_wval;
            dm_we    = s1_adv && ex_ctl.store;
            dm_waddr = ex_mem_index;
            dm_wdata = ex_sval;
        end
    end

    // Register file: two copies give the two read ports.
    mse_ram #(
        .WIDTH (32),
        .DEPTH (mse_pkg::RF_DEPTH)
    ) u_rf_a (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (in_accept),
        .raddr (instruction[23:21]),
        .rdata (rf_a_rdata)
    );

    mse_ram #(
        .WIDTH (32),
        .DEPTH (mse_pkg::RF_DEPTH)
    ) u_rf_b (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (in_accept),
        .raddr (instruction[18:16]),
        .rdata (rf_b_rdata)
    );

    // Data memory; read data holds while the result stage is stalled.
    mse_ram #(
        .WIDTH (32),
        .DEPTH (MEM_WORDS)
    ) u_dmem (
        .clk   (clk),
        .we    (dm_we),
        .waddr (dm_waddr),
        .wdata (dm_wdata),
        .re    (s1_adv),
        .raddr (ex_mem_index),
        .rdata (dm_rdata)
    );

    // Next state of the control registers.
    always_comb
    begin
        clearing_next  = clearing_reg;
        clr_cnt_next   = clr_cnt_reg;
        s1_valid_next  = s1_valid_reg;
        s2_valid_next  = s2_valid_reg;
        fwd_a_hit_next = fwd_a_hit_reg;
        fwd_b_hit_next = fwd_b_hit_reg;
        pc_next        = pc_reg;

        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + CNT_W'(1);
            if (clr_cnt_reg == CNT_W'(CLR_COUNT - 1))
            begin
                clearing_next = 1'b0;
            end
        end

        if (in_accept)
        begin
            s1_valid_next  = 1'b1;
            fwd_a_hit_next = s2_wr && (s2_ctl_reg.dest == instruction[23:21]);
            fwd_b_hit_next = s2_wr && (s2_ctl_reg.dest == instruction[18:16]);
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        if (s1_adv)
        begin
            s2_valid_next = 1'b1;
            pc_next       = ex_npc;
        end
        else if (!out_stall)
        begin
            s2_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            fwd_a_hit_reg <= 1'b0;
            fwd_b_hit_reg <= 1'b0;
            pc_reg        <= '0;
        end
        else
        begin
            clearing_reg  <= clearing_next;
            clr_cnt_reg   <= clr_cnt_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            fwd_a_hit_reg <= fwd_a_hit_next;
            fwd_b_hit_reg <= fwd_b_hit_next;
            pc_reg        <= pc_next;
        end
    end

    // Payload registers of the execute and result stages.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_ins_reg    <= instruction;
            fwd_a_val_reg <= s2_wval;
            fwd_b_val_reg <= s2_wval;
        end
        if (s1_adv)
        begin
            s2_ctl_reg  <= ex_ctl;
            s2_val_reg  <= ex_wval;
            s2_sval_reg <= ex_sval;
            s2_npc_reg  <= ex_npc;
        end
    end

    // Result word.
    assign npc_wide      = 32'(s2_npc_reg);
    assign out_valid     = s2_valid_reg;
    assign next_pc       = npc_wide[15:0];
    assign reg_written   = s2_ctl_reg.reg_wr;
    assign dest_index    = s2_ctl_reg.dest;
    assign dest_value    = s2_wval;
    assign store_done    = s2_ctl_reg.store;
    assign store_address = s2_ctl_reg.addr5;
    assign store_value   = s2_sval_reg;
    assign address_error = s2_ctl_reg.addr_err;
    assign halted        = s2_ctl_reg.halt;

endmodule

@@ rtl/core/mse_checker.sv @@
// ----------------------------------------------------------------------------
// mse_checker
// Port-level checks of the instruction executor, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "mips_subset_instruction_executor_defines.svh"

module mse_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        reg_written,
    input logic [2:0]  dest_index,
    input logic [31:0] dest_value,
    input logic        store_done,
    input logic [31:0] store_value,
    input logic        address_error,
    input logic        halted
);

    // A stalled result word keeps its write fields.
    `MSE_CHECK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(dest_value) && $stable(store_value), "stalled result word changed")

    // A failed address check accesses neither the register file nor memory.
    `MSE_CHECK(a_addr_err_no_access, out_valid && address_error, !reg_written && !store_done, "access despite address error")

    // A store never writes a register, and the halt word does neither.
    `MSE_CHECK(a_store_or_halt, out_valid && (store_done || halted), !reg_written, "store or halt wrote a register")

    // With no register write the write fields read as zero.
    `MSE_CHECK(a_no_write_zero, out_valid && !reg_written, (dest_index == 3'd0) && (dest_value == 32'd0), "write fields not zero")

endmodule

bind mips_subset_instruction_executor mse_checker u_mse_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .reg_written   (reg_written),
    .dest_index    (dest_index),
    .dest_value    (dest_value),
    .store_done    (store_done),
    .store_value   (store_value),
    .address_error (address_error),
    .halted        (halted)
);

@@ tb/tb_mips_subset_instruction_executor.sv @@
// ----------------------------------------------------------------------------
// tb_mips_subset_instruction_executor
// Drives instruction words into the executor and checks every result word
// against an in-order model of registers, data memory and program counter.
// Directed words cover each operation, the address and branch limits and the
// halt word; random programs follow with random gaps on both channels, a
// gap-free streaming stretch and pure noise words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_mips_subset_instruction_executor;

    localparam int          MEM_DEPTH    = 32;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          PRINT_LIMIT  = 40;
    localparam int          GAP_PERCENT  = 38;
    // Instruction bits that no supported format decodes.
    localparam logic [31:0] R_FREE_MASK  = 32'h0318_C7C0;
    localparam logic [31:0] I_FREE_MASK  = 32'h0318_0000;

    // One executed word as seen on the result channel.
    typedef struct packed {
        logic [15:0] next_pc;
        logic        reg_written;
        logic [2:0]  dest_index;
        logic [31:0] dest_value;
        logic        store_done;
        logic [4:0]  store_address;
        logic [31:0] store_value;
        logic        address_error;
        logic        halted;
    } exec_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] instruction;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] next_pc;
    logic        reg_written;
    logic [2:0]  dest_index;
    logic [31:0] dest_value;
    logic        store_done;
    logic [4:0]  store_address;
    logic [31:0] store_value;
    logic        address_error;
    logic        halted;

    // Architectural state of the model.
    logic [31:0] gpr [mse_pkg::RF_DEPTH];
    logic [31:0] dmem [MEM_DEPTH];
    logic [15:0] pc;
    int          last_store_addr;

    exec_result_t pending_results[$];
    int           error_count  = 0;
    int           result_count = 0;
    int           cycle_count  = 0;
    bit           gaps_on      = 1'b1;

    mips_subset_instruction_executor u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .instruction  (instruction),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .next_pc      (next_pc),
        .reg_written  (reg_written),
        .dest_index   (dest_index),
        .dest_value   (dest_value),
        .store_done   (store_done),
        .store_address(store_address),
        .store_value  (store_value),
        .address_error(address_error),
        .halted       (halted)
    );

    // Clock with a 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Encoders for the two instruction formats.
    function automatic logic [31:0] r_word(logic [5:0] fn, logic [2:0] rd, logic [2:0] rs,
                                           logic [2:0] rt);
        return {mse_pkg::OP_RTYPE, 2'b00, rs, 2'b00, rt, 2'b00, rd, 5'b00000, fn};
    endfunction

    function automatic logic [31:0] i_word(logic [5:0] op, logic [2:0] rs, logic [2:0] rt,
                                           logic [15:0] imm);
        return {op, 2'b00, rs, 2'b00, rt, imm};
    endfunction

    // Executes one word on the model state and returns the result it gives.
    function automatic exec_result_t execute_word(logic [31:0] w);
        exec_result_t res;
        logic [5:0]   op;
        logic [5:0]   fn;
        logic [31:0]  a;
        logic [31:0]  b;
        logic [31:0]  simm;
        longint       addr;
        logic [15:0]  npc;
        op   = w[31:26];
        fn   = w[5:0];
        a    = gpr[w[23:21]];
        b    = gpr[w[18:16]];
        simm = {{16{w[15]}}, w[15:0]};
        npc  = pc + 16'd1;
        res  = '0;
        if (op == mse_pkg::OP_RTYPE)
        begin
            res.reg_written = 1'b1;
            res.dest_index  = w[13:11];
            case (fn)
                mse_pkg::FN_ADD: res.dest_value = a + b;
                mse_pkg::FN_AND: res.dest_value = a & b;
                mse_pkg::FN_OR:  res.dest_value = a | b;
                mse_pkg::FN_NOR: res.dest_value = ~(a | b);
                mse_pkg::FN_SLT: res.dest_value = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                default:
                begin
                    res.reg_written = 1'b0;
                    res.dest_index  = 3'd0;
                end
            endcase
        end
        else if (op == mse_pkg::OP_LW || op == mse_pkg::OP_SW)
        begin
            // The address is formed without wrap, so large bases stay out of range.
            addr = longint'($signed(a)) + longint'($signed(simm));
            if (addr < 0 || addr >= MEM_DEPTH)
            begin
                res.address_error = 1'b1;
            end
            else
            begin
                res.store_address = addr[4:0];
                if (op == mse_pkg::OP_LW)
                begin
                    res.reg_written = 1'b1;
                    res.dest_index  = w[18:16];
                    res.dest_value  = dmem[addr];
                end
                else
                begin
                    res.store_done  = 1'b1;
                    res.store_value = b;
                    dmem[addr]      = b;
                    last_store_addr = int'(addr);
                end
            end
        end
        else if (op == mse_pkg::OP_BEQ && a == b)
        begin
            npc = npc + simm[15:0];
        end
        if (res.reg_written)
            gpr[res.dest_index] = res.dest_value;
        pc          = npc;
        res.next_pc = npc;
        res.halted  = (w == mse_pkg::HALT_WORD);
        return res;
    endfunction

    // Builds a random word, mostly well formed and mostly hitting memory.
    function automatic logic [31:0] random_word();
        int unsigned pick;
        int          target;
        longint      diff;
        int          bases[$];
        logic [5:0]  op;
        logic [5:0]  fn;
        logic [2:0]  rs;
        logic [2:0]  rt;
        logic [15:0] imm;
        pick = $urandom_range(0, 99);
        rs   = 3'($urandom_range(0, 7));
        rt   = 3'($urandom_range(0, 7));
        if (pick < 45)
        begin
            case ($urandom_range(0, 4))
                0:       fn = mse_pkg::FN_ADD;
                1:       fn = mse_pkg::FN_AND;
                2:       fn = mse_pkg::FN_OR;
                3:       fn = mse_pkg::FN_NOR;
                default: fn = mse_pkg::FN_SLT;
            endcase
            return r_word(fn, 3'($urandom_range(0, 7)), rs, rt) | ($urandom & R_FREE_MASK);
        end
        else if (pick < 80)
        begin
            op = (pick < 62) ? mse_pkg::OP_LW : mse_pkg::OP_SW;
            case ($urandom_range(0, 9))
                0:       target = -1 - int'($urandom_range(0, 3));
                1:       target = MEM_DEPTH + int'($urandom_range(0, 3));
                2, 3:    target = last_store_addr;
                default: target = int'($urandom_range(0, MEM_DEPTH - 1));
            endcase
            // Pick a base register close enough for the immediate to reach the target.
            for (int i = 0; i < mse_pkg::RF_DEPTH; i++)
            begin
                diff = longint'(target) - longint'($signed(gpr[i]));
                if (diff >= -32768 && diff <= 32767)
                    bases.push_back(i);
            end
            if (bases.size() == 0)
            begin
                imm = 16'($urandom);
            end
            else
            begin
                rs   = 3'(bases[$urandom_range(0, bases.size() - 1)]);
                diff = longint'(target) - longint'($signed(gpr[rs]));
                imm  = diff[15:0];
            end
            return i_word(op, rs, rt, imm) | ($urandom & I_FREE_MASK);
        end
        else if (pick < 88)
        begin
            if ($urandom_range(0, 1) == 0)
                rt = rs;
            if ($urandom_range(0, 3) == 0)
                imm = 16'($urandom);
            else
                imm = 16'($signed(int'($urandom_range(0, 16)) - 8));
            return i_word(mse_pkg::OP_BEQ, rs, rt, imm) | ($urandom & I_FREE_MASK);
        end
        else if (pick < 92)
        begin
            return mse_pkg::HALT_WORD;
        end
        else if (pick < 96)
        begin
            do
                fn = 6'($urandom);
            while (fn inside {mse_pkg::FN_ADD, mse_pkg::FN_AND, mse_pkg::FN_OR,
                              mse_pkg::FN_NOR, mse_pkg::FN_SLT});
            return r_word(fn, 3'($urandom_range(0, 7)), rs, rt) | ($urandom & R_FREE_MASK);
        end
        return $urandom;
    endfunction

    // Sends one word and records its expected result once it is accepted.
    task automatic send_word(input logic [31:0] w);
        while (gaps_on && $urandom_range(0, 99) < GAP_PERCENT)
        begin
            in_valid    <= 1'b0;
            instruction <= $urandom;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        instruction <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(execute_word(w));
    endtask

    // Prints one mismatch line, up to a limit, and counts it.
    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < PRINT_LIMIT)
            $display("ERROR: word %0d %s: got %h, expected %h", result_count, field, got, want);
        error_count++;
    endtask

    // Result stall: random stalls while gaps are on.
    always @(posedge clk)
    begin
        out_stall <= gaps_on && ($urandom_range(0, 99) < GAP_PERCENT);
    end

    // Compares every accepted result word with the oldest pending one.
    always @(posedge clk)
    begin
        exec_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result, next_pc", 32'(next_pc), 32'd0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (next_pc !== want.next_pc)
                    report_mismatch("next_pc", 32'(next_pc), 32'(want.next_pc));
                if (reg_written !== want.reg_written)
                    report_mismatch("reg_written", 32'(reg_written), 32'(want.reg_written));
                if (dest_index !== want.dest_index)
                    report_mismatch("dest_index", 32'(dest_index), 32'(want.dest_index));
                if (dest_value !== want.dest_value)
                    report_mismatch("dest_value", dest_value, want.dest_value);
                if (store_done !== want.store_done)
                    report_mismatch("store_done", 32'(store_done), 32'(want.store_done));
                if (store_address !== want.store_address)
                    report_mismatch("store_address", 32'(store_address),
                                    32'(want.store_address));
                if (store_value !== want.store_value)
                    report_mismatch("store_value", store_value, want.store_value);
                if (address_error !== want.address_error)
                    report_mismatch("address_error", 32'(address_error),
                                    32'(want.address_error));
                if (halted !== want.halted)
                    report_mismatch("halted", 32'(halted), 32'(want.halted));
            end
            result_count++;
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Every ALU function, signed compare both ways and equal, carry out,
    // register zero as a destination and an undecoded function code.
    task automatic test_register_ops();
        send_word(r_word(mse_pkg::FN_NOR, 3'd1, 3'd0, 3'd0));
        send_word(r_word(mse_pkg::FN_SLT, 3'd2, 3'd1, 3'd0));
        send_word(r_word(mse_pkg::FN_SLT, 3'd5, 3'd0, 3'd1));
        send_word(r_word(mse_pkg::FN_SLT, 3'd5, 3'd1, 3'd1));
        send_word(r_word(mse_pkg::FN_ADD, 3'd3, 3'd2, 3'd2));
        send_word(r_word(mse_pkg::FN_ADD, 3'd4, 3'd1, 3'd1));
        send_word(r_word(mse_pkg::FN_AND, 3'd6, 3'd1, 3'd3));
        send_word(r_word(mse_pkg::FN_OR, 3'd7, 3'd4, 3'd2));
        send_word(r_word(mse_pkg::FN_ADD, 3'd0, 3'd2, 3'd3));
        send_word(r_word(mse_pkg::FN_ADD, 3'd6, 3'd0, 3'd0));
        send_word(r_word(6'h00, 3'd7, 3'd1, 3'd1));
    endtask

    // Stores and loads at both ends of memory, a negative base and
    // addresses just outside on either side.
    task automatic test_memory_access();
        send_word(i_word(mse_pkg::OP_SW, 3'd3, 3'd1, 16'd29));
        send_word(i_word(mse_pkg::OP_SW, 3'd3, 3'd7, 16'hfffe));
        send_word(i_word(mse_pkg::OP_LW, 3'd0, 3'd5, 16'd28));
        send_word(i_word(mse_pkg::OP_LW, 3'd0, 3'd6, 16'hfffc));
        send_word(i_word(mse_pkg::OP_SW, 3'd0, 3'd2, 16'd29));
        send_word(i_word(mse_pkg::OP_LW, 3'd1, 3'd4, 16'd1));
    endtask

    // Branches that wrap the counter, fall through or jump furthest,
    // the halt word and its near miss, and the all-zero and all-one words.
    task automatic test_branch_and_flags();
        send_word(i_word(mse_pkg::OP_BEQ, 3'd0, 3'd0, 16'hff9c));
        send_word(i_word(mse_pkg::OP_BEQ, 3'd1, 3'd2, 16'd5));
        send_word(i_word(mse_pkg::OP_BEQ, 3'd5, 3'd5, 16'h7fff));
        send_word(mse_pkg::HALT_WORD);
        send_word(mse_pkg::HALT_WORD | 32'd1);
        send_word(32'hffff_ffff);
        send_word(32'h0000_0000);
    endtask

    // Random programs with random gaps on both channels.
    task automatic test_random_program();
        repeat (420)
            send_word(random_word());
    endtask

    // Random programs streamed with no gaps and no stalls.
    task automatic test_back_to_back();
        gaps_on = 1'b0;
        repeat (120)
            send_word(random_word());
        gaps_on = 1'b1;
    endtask

    // Fully random words.
    task automatic test_noise_words();
        repeat (40)
            send_word($urandom);
    endtask

    initial
    begin
        in_valid        = 1'b0;
        instruction     = 32'd0;
        rst_n           = 1'b0;
        pc              = 16'd0;
        last_store_addr = 0;
        for (int i = 0; i < mse_pkg::RF_DEPTH; i++)
            gpr[i] = 32'd0;
        for (int i = 0; i < MEM_DEPTH; i++)
            dmem[i] = 32'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_register_ops();
        test_memory_access();
        test_branch_and_flags();
        test_random_program();
        test_back_to_back();
        test_noise_words();

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ mips_subset_instruction_executor.f @@
+incdir+rtl/core
rtl/core/mse_pkg.sv
rtl/core/mse_ram.sv
rtl/core/mse_exec.sv
rtl/core/mips_subset_instruction_executor.sv
rtl/core/mse_checker.sv
tb/tb_mips_subset_instruction_executor.sv
